>>> hdl/sorted_table_binary_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table search block
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table search package
// Sizes, codes, types and helper functions shared by the search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ENTRY_WIDTH = 32;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int CFG_W   = 11;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 10;
   localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef logic [IDX_W-1:0]              idx_type;
   typedef logic [CNT_W-1:0]              cnt_type;
   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      logic      rd_en;
      idx_type   rd_addr;
   } ram_cmd_type;

   // The low entry bits of the value, sign-extended when the entry is wider.
   function automatic entry_type to_entry(input logic [VALUE_W-1:0] v);
      logic [63:0] wide;
      wide = {{(64 - VALUE_W){v[VALUE_W-1]}}, v};
      return wide[ENTRY_WIDTH-1:0];
   endfunction

   // Probe of the half-open interval [lo, hi); the caller ensures lo < hi.
   function automatic idx_type mid_of(input cnt_type lo, input cnt_type hi);
      cnt_type span;
      cnt_type m;
      span = hi - lo - cnt_type'(1);
      m    = lo + (span >> 1);
      return m[IDX_W-1:0];
   endfunction

   // Entry count limited to the table depth.
   function automatic cnt_type clamp_count(input logic [CFG_W-1:0] cfg);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(cfg);
      if (ext > CMP_W'(TABLE_DEPTH)) begin
         return CNT_W'(TABLE_DEPTH);
      end
      return CNT_W'(ext);
   endfunction

endpackage

>>> hdl/stbs_channels.sv
// ----------------------------------------------------------------------------
// Sorted table search channels
// Valid/ready interfaces for requests, responses and the count register.
// ----------------------------------------------------------------------------
interface stbs_req_if;
   import stbs_pkg::*;

   logic               valid;
   logic               ready;
   logic               operation;
   logic [INDEX_W-1:0] entry_index;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output operation, output entry_index, output value,
                   input ready);
   modport sink   (input valid, input operation, input entry_index, input value,
                   output ready);
endinterface

interface stbs_rsp_if;
   import stbs_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

interface stbs_csr_if;
   import stbs_pkg::*;

   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] entries_in_use;

   modport source (output valid, output entries_in_use, input ready);
   modport sink   (input valid, input entries_in_use, output ready);
endinterface

>>> hdl/stbs_table_ram.sv
// ----------------------------------------------------------------------------
// Sorted table RAM
// Simple dual-port synchronous RAM with one write and one registered read.
// ----------------------------------------------------------------------------
module stbs_table_ram #(
   parameter int  DEPTH  = 1024,
   parameter int  DATA_W = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/stbs_search_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted table search controller
// Takes write and search transactions, steps the binary search through the
// table RAM one probe per cycle and stages each result for the response port.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_defines.svh"

module stbs_search_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   stbs_req_if.sink             req,
   stbs_rsp_if.source           rsp,
   stbs_csr_if.sink             csr,
   output stbs_pkg::ram_cmd_type ram_cmd,
   input  stbs_pkg::entry_type  ram_rd_data
);
   import stbs_pkg::*;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] entries_ff;
   cnt_type          lo_ff, lo_in;
   cnt_type          hi_ff, hi_in;
   idx_type          mid_ff, mid_in;
   entry_type        target_ff, target_in;
   logic             res_found_ff, res_found_in;
   logic [POS_W-1:0] res_pos_ff, res_pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   logic [POS_W-1:0] rsp_pos_ff;

   logic    req_fire;
   logic    slot_free;
   logic    rsp_load;
   logic    hit;
   logic    greater;
   logic    empty;
   logic    in_range;
   cnt_type count;
   cnt_type lo_step;
   cnt_type hi_step;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign rsp_load  = (state_ff == ST_REPLY) && slot_free;

   assign count    = clamp_count(entries_ff);
   assign in_range = (32'(req.entry_index) < TABLE_DEPTH);

   // The RAM output holds the entry at mid_ff while the search is running.
   assign hit     = (ram_rd_data == target_ff);
   assign greater = (ram_rd_data > target_ff);
   assign lo_step = greater ? lo_ff : (cnt_type'(mid_ff) + cnt_type'(1));
   assign hi_step = greater ? cnt_type'(mid_ff) : hi_ff;
   assign empty   = (lo_step >= hi_step);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req.operation == OP_SEARCH) && (count != '0)) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_SEARCH: begin
            if (hit || empty) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      target_in       = target_ff;
      res_found_in    = res_found_ff;
      res_pos_in      = res_pos_ff;
      ram_cmd.wr_en   = 1'b0;
      ram_cmd.wr_addr = IDX_W'(req.entry_index);
      ram_cmd.wr_data = to_entry(req.value);
      ram_cmd.rd_en   = 1'b0;
      ram_cmd.rd_addr = mid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_found_in = 1'b0;
               res_pos_in   = '0;
               if (req.operation == OP_WRITE) begin
                  ram_cmd.wr_en = in_range;
               end else begin
                  target_in       = to_entry(req.value);
                  lo_in           = '0;
                  hi_in           = count;
                  mid_in          = mid_of('0, count);
                  ram_cmd.rd_en   = (count != '0);
                  ram_cmd.rd_addr = mid_in;
               end
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               res_found_in = 1'b1;
               res_pos_in   = POS_W'(mid_ff);
            end else if (!empty) begin
               lo_in           = lo_step;
               hi_in           = hi_step;
               mid_in          = mid_of(lo_step, hi_step);
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = mid_in;
            end
         end
         ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            entries_ff <= csr.entries_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      target_ff    <= target_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      if (rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = rsp_found_ff;
   assign rsp.position = rsp_pos_ff;

   `STBS_ASSERT_NOW(a_interval_ordered, clock, reset, state_ff == ST_SEARCH,
      (lo_ff < hi_ff) && (hi_ff <= cnt_type'(TABLE_DEPTH)), "search interval is empty or too wide")
   `STBS_ASSERT_NOW(a_probe_inside, clock, reset, state_ff == ST_SEARCH,
      (cnt_type'(mid_ff) >= lo_ff) && (cnt_type'(mid_ff) < hi_ff), "probe outside interval")
   `STBS_ASSERT_NOW(a_probe_was_read, clock, reset, state_ff == ST_SEARCH,
      $past(ram_cmd.rd_en) && ($past(ram_cmd.rd_addr) == mid_ff), "compare without matching read")

endmodule

>>> hdl/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// Sorted table binary search
// Table of signed entries in a synchronous RAM with a binary search engine.
// ----------------------------------------------------------------------------
// Each request transaction produces exactly one response transaction. A write
// stores one entry and answers with found = 0, position = 0; a write beyond
// the table depth is dropped. A search covers the first entries_in_use entries
// (limited to the depth) and makes p probes in ST_SEARCH, where p is at most
// floor(log2(entries_in_use)) + 1, so 11 for a full 1024-entry table. Either
// request then waits in ST_REPLY until the response register is free, and
// rsp_chan.valid rises once the result is staged into that register.
// The probe loop runs through the table RAM's single registered read port,
// one probe per cycle, since each address follows from the previous compare.
// A new request is taken once the previous response is staged, even while
// that response still waits on rsp_chan.ready. The count register may only
// be written while no transaction is in flight. Entries read before they
// were written return undefined data; there is no clearing pass.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
   input  logic       clock,
   input  logic       reset,
   stbs_req_if.sink   req_chan,
   stbs_rsp_if.source rsp_chan,
   stbs_csr_if.sink   csr_chan
);
   import stbs_pkg::*;

   ram_cmd_type ram_cmd;
   entry_type   ram_rd_data;

   stbs_search_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr         (csr_chan),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   stbs_table_ram #(
      .DEPTH  (TABLE_DEPTH),
      .DATA_W (ENTRY_WIDTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> verif/tb_sorted_table_binary_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table binary search testbench
// Loads ascending tables through write transactions, sweeps the entry count
// and checks every response against a shadow table and a behavioral search.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;
   import stbs_pkg::*;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } lookup_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;

   stbs_req_if req_chan();
   stbs_rsp_if rsp_chan();
   stbs_csr_if csr_chan();

   sorted_table_binary_search uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   entry_type          shadow_table [TABLE_DEPTH];
   logic [CFG_W-1:0]   shadow_count;
   lookup_outcome_type awaited_lookups [$];
   int                 mismatches;
   int                 sent_items;

   always #5 clock = ~clock;

   // Applies one request to the shadow table and returns the response it must give.
   function automatic lookup_outcome_type predict_lookup(input logic op,
                                                         input logic [INDEX_W-1:0] idx,
                                                         input logic [VALUE_W-1:0] val);
      lookup_outcome_type outcome;
      entry_type          target;
      int                 lo;
      int                 hi;
      int                 mid;
      int                 span;
      outcome = '0;
      target  = entry_type'(signed'(val));
      if (op == OP_WRITE) begin
         if (int'(idx) < TABLE_DEPTH) begin
            shadow_table[idx] = target;
         end
         return outcome;
      end
      span = (int'(shadow_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
      lo   = 0;
      hi   = span - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_table[mid] == target) begin
            outcome.found    = 1'b1;
            outcome.position = POS_W'(mid);
            return outcome;
         end
         if (shadow_table[mid] > target) begin
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return outcome;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] val);
      if (!steady) begin
         while ($urandom_range(99) < 6) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.entry_index <= idx;
      req_chan.value       <= val;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      awaited_lookups.push_back(predict_lookup(op, idx, val));
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (awaited_lookups.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // The count register may only change while no transaction is in flight.
   task automatic write_entry_count(input logic [CFG_W-1:0] count);
      wait_for_results();
      csr_chan.valid          <= 1'b1;
      csr_chan.entries_in_use <= count;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      shadow_count = count;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic load_sorted_prefix(input int depth);
      int vals [$];
      vals = {};
      repeat (depth) vals.push_back($urandom);
      vals.sort();
      for (int i = 0; i < depth; i++) begin
         // Occasional duplicates keep the table ascending but not strictly.
         if (i > 0 && $urandom_range(9) == 0) begin
            vals[i] = vals[i-1];
         end
         send_request(OP_WRITE, INDEX_W'(i), vals[i]);
      end
   endtask

   // Targets are mostly stored values or their neighbors, the rest random.
   task automatic run_searches(input int count, input int span);
      logic [VALUE_W-1:0] target;
      repeat (count) begin
         target = $urandom;
         if (span > 0) begin
            case ($urandom_range(9)) inside
               [0:4]: begin
                  target = shadow_table[$urandom_range(0, span - 1)];
               end
               5: begin
                  target = shadow_table[$urandom_range(0, span - 1)] + 1;
               end
               6: begin
                  target = shadow_table[$urandom_range(0, span - 1)] - 1;
               end
               default: begin
               end
            endcase
         end
         send_request(OP_SEARCH, INDEX_W'($urandom), target);
         if ($urandom_range(49) == 0) begin
            wait_for_results();
         end
      end
   endtask

   task automatic test_empty_range();
      write_entry_count('0);
      send_request(OP_SEARCH, '0, '0);
      send_request(OP_SEARCH, '1, 32'h7FFF_FFFF);
   endtask

   task automatic test_directed_table();
      logic [VALUE_W-1:0] ladder [7] = '{32'h8000_0000, -32'sd1000, -32'sd1, 32'h0,
                                        32'h1, 32'd1000, 32'h7FFF_FFFF};
      for (int i = 0; i < 7; i++) begin
         send_request(OP_WRITE, INDEX_W'(i), ladder[i]);
      end
      send_request(OP_WRITE, '1, 32'h5555_AAAA);
      write_entry_count(CFG_W'(7));
      send_request(OP_SEARCH, '0, 32'h8000_0000);
      send_request(OP_SEARCH, '0, 32'h0);
      send_request(OP_SEARCH, '1, 32'h7FFF_FFFF);
      send_request(OP_SEARCH, '0, -32'sd2);
      send_request(OP_SEARCH, '0, 32'd999);
      write_entry_count(CFG_W'(1));
      send_request(OP_SEARCH, '0, 32'h8000_0000);
      send_request(OP_SEARCH, '0, 32'd1000);
   endtask

   // The maximum at the front and the minimum at the back send the probes astray.
   task automatic test_unsorted_probe();
      send_request(OP_WRITE, INDEX_W'(0), 32'h7FFF_FFFF);
      send_request(OP_WRITE, INDEX_W'(4), 32'h8000_0000);
      write_entry_count(CFG_W'(5));
      send_request(OP_SEARCH, '0, 32'h7FFF_FFFF);
      send_request(OP_SEARCH, '0, -32'sd1);
      send_request(OP_SEARCH, '0, 32'h0);
   endtask

   task automatic test_random_tables();
      int depth;
      while (sent_items < 40) begin
         depth = ($urandom_range(9) == 0) ? $urandom_range(49, 160) : $urandom_range(1, 48);
         load_sorted_prefix(depth);
         if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(1) == 0) begin
                  send_request(OP_WRITE, INDEX_W'($urandom_range(0, depth - 1)), $urandom);
               end else begin
                  send_request(OP_WRITE, INDEX_W'($urandom_range(depth, TABLE_DEPTH - 1)),
                               $urandom);
               end
            end
         end
         write_entry_count(($urandom_range(4) == 0) ? CFG_W'($urandom_range(0, depth))
                                                    : CFG_W'(depth));
         run_searches($urandom_range(8, 24), depth);
      end
   endtask

   // Fills every position, then runs counts at, below and above the depth.
   task automatic test_full_table();
      steady = 1'b1;
      load_sorted_prefix(TABLE_DEPTH);
      steady = 1'b0;
      write_entry_count(CFG_W'(TABLE_DEPTH));
      run_searches(40, TABLE_DEPTH);
      write_entry_count('1);
      run_searches(30, TABLE_DEPTH);
      write_entry_count(CFG_W'(TABLE_DEPTH + 1));
      run_searches(20, TABLE_DEPTH);
      write_entry_count(CFG_W'(TABLE_DEPTH - 1));
      run_searches(20, TABLE_DEPTH);
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= 6);
   end

   always @(posedge clock) begin
      lookup_outcome_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (awaited_lookups.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual found=%0b position=%0d",
                     $time, rsp_chan.found, rsp_chan.position);
            mismatches++;
         end else begin
            want = awaited_lookups.pop_front();
            if (rsp_chan.found !== want.found) begin
               $display("%0t: found mismatch, expected %0b, actual %0b",
                        $time, want.found, rsp_chan.found);
               mismatches++;
            end
            if (rsp_chan.position !== want.position) begin
               $display("%0t: position mismatch, expected %0d, actual %0d",
                        $time, want.position, rsp_chan.position);
               mismatches++;
            end
         end
      end
   end

   initial begin
      req_chan.valid          = 1'b0;
      req_chan.operation      = OP_WRITE;
      req_chan.entry_index    = '0;
      req_chan.value          = '0;
      rsp_chan.ready          = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.entries_in_use = '0;
      shadow_count            = '0;
      mismatches              = 0;
      sent_items              = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_range();
      test_directed_table();
      test_unsorted_probe();
      test_random_tables();
      test_full_table();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && awaited_lookups.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
